// ===== src/adts_pkg.sv =====
`default_nettype none

package adts_pkg;

   localparam int RATE_COUNT = 13;

   // register indexes on the csr port
   localparam logic [1:0] CSR_RATE_HZ  = 2'd0;
   localparam logic [1:0] CSR_CHAN_NUM = 2'd1;
   localparam logic [1:0] CSR_PROFILE  = 2'd2;

   localparam logic [3:0] RATE_IDX_EXPLICIT = 4'd15;
   localparam logic [2:0] CHAN_CFG_CAP      = 3'd7;
   localparam logic [3:0] HDR_LEN_BASE      = 4'd7;
   localparam logic [3:0] HDR_LEN_EXPLICIT  = 4'd10;
   localparam logic [3:0] HDR_LAST_BASE     = 4'd6;
   localparam logic [3:0] HDR_LAST_EXPLICIT = 4'd9;

   localparam logic [7:0]  HDR_SYNC      = 8'hFF;
   localparam logic [7:0]  HDR_ID_BYTE   = 8'hF9;
   localparam logic [10:0] BUF_FULLNESS  = 11'h7FF;

   // header byte positions
   localparam logic [3:0] POS_SYNC    = 4'd0;
   localparam logic [3:0] POS_ID      = 4'd1;
   localparam logic [3:0] POS_PROFILE = 4'd2;
   localparam logic [3:0] POS_LEN_HI  = 4'd3;
   localparam logic [3:0] POS_LEN_MID = 4'd4;
   localparam logic [3:0] POS_LEN_LO  = 4'd5;
   localparam logic [3:0] POS_FULL_LO = 4'd6;
   localparam logic [3:0] POS_RATE_HI = 4'd7;
   localparam logic [3:0] POS_RATE_MD = 4'd8;
   localparam logic [3:0] POS_RATE_LO = 4'd9;

   localparam logic [23:0] STD_RATES [RATE_COUNT] = '{
      24'd96000, 24'd88200, 24'd64000, 24'd48000, 24'd44100, 24'd32000, 24'd24000,
      24'd22050, 24'd16000, 24'd12000, 24'd11025, 24'd8000, 24'd7350
   };

   typedef struct packed {
      logic [23:0] rate_hz;
      logic [3:0]  chan_num;
      logic [1:0]  profile;
   } cfg_type;

   // one classified frame, everything the back end needs to build its header
   typedef struct packed {
      logic [1:0]  profile;
      logic [3:0]  rate_idx;
      logic [2:0]  chan_cfg;
      logic [12:0] frame_len;
      logic        overflow;
      logic        explicit_rate;
      logic [23:0] rate_hz;
   } frame_desc_type;

   function automatic logic [3:0] rate_index(input logic [23:0] rate);
      logic [3:0] idx;
      idx = RATE_IDX_EXPLICIT;
      // rates are distinct, so at most one compare hits
      for (int i = RATE_COUNT - 1; i >= 0; i--) begin
         if (STD_RATES[i] == rate) begin
            idx = 4'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [7:0] header_byte(input frame_desc_type d, input logic [3:0] pos);
      logic [7:0] b;
      case (pos)
         POS_SYNC:    b = HDR_SYNC;
         POS_ID:      b = HDR_ID_BYTE;
         POS_PROFILE: b = {d.profile, d.rate_idx, 1'b0, d.chan_cfg[2]};
         POS_LEN_HI:  b = {d.chan_cfg[1:0], 4'b0000, d.frame_len[12:11]};
         POS_LEN_MID: b = d.frame_len[10:3];
         POS_LEN_LO:  b = {d.frame_len[2:0], BUF_FULLNESS[10:6]};
         POS_FULL_LO: b = {BUF_FULLNESS[5:0], 2'b00};
         POS_RATE_HI: b = d.rate_hz[23:16];
         POS_RATE_MD: b = d.rate_hz[15:8];
         POS_RATE_LO: b = d.rate_hz[7:0];
         default:     b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== src/adts_front.sv =====
`default_nettype none

module adts_front (
   input  wire                    clock,
   input  wire                    reset,
   input  adts_pkg::cfg_type      cfg,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire [12:0]             req_payload_size,
   output logic                   push,
   output adts_pkg::frame_desc_type push_desc,
   input  wire                    queue_full
);
   import adts_pkg::*;

   logic           front_valid_ff, front_valid_in;
   frame_desc_type desc_ff, desc_in;
   logic           req_accept;
   logic [3:0]     idx;
   logic           explicit_rate;
   logic [13:0]    full_len;

   assign req_stall  = front_valid_ff & queue_full;
   assign req_accept = req_valid & ~req_stall;
   assign push       = front_valid_ff & ~queue_full;
   assign push_desc  = desc_ff;

   always_comb begin
      idx           = rate_index(cfg.rate_hz);
      explicit_rate = (idx == RATE_IDX_EXPLICIT);
      full_len      = {1'b0, req_payload_size}
                      + {10'd0, (explicit_rate ? HDR_LEN_EXPLICIT : HDR_LEN_BASE)};
      desc_in.profile       = cfg.profile;
      desc_in.rate_idx      = idx;
      desc_in.chan_cfg      = (cfg.chan_num > {1'b0, CHAN_CFG_CAP}) ?
                              CHAN_CFG_CAP : cfg.chan_num[2:0];
      desc_in.frame_len     = full_len[12:0];
      desc_in.overflow      = full_len[13];
      desc_in.explicit_rate = explicit_rate;
      desc_in.rate_hz       = cfg.rate_hz;
      front_valid_in        = req_accept | (front_valid_ff & ~push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         desc_ff <= desc_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/adts_queue.sv =====
`default_nettype none

module adts_queue #(
   parameter int DEPTH = 2
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  adts_pkg::frame_desc_type push_desc,
   output logic                     full,
   input  wire                      pop,
   output logic                     head_valid,
   output adts_pkg::frame_desc_type head_desc
);
   import adts_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_desc_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// ===== src/adts_back.sv =====
`default_nettype none

module adts_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      head_valid,
   input  adts_pkg::frame_desc_type head_desc,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [7:0]               rsp_header_byte,
   output logic [3:0]               rsp_byte_position,
   output logic                     rsp_last_byte,
   output logic                     rsp_length_overflow
);
   import adts_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] pos_ff, pos_in;
   logic [7:0] byte_ff;
   logic [3:0] byte_pos_ff;
   logic       last_ff, ovf_ff;
   logic       out_load, emit, is_last;

   assign out_load = ~rsp_valid_ff | ~rsp_stall;
   assign emit     = out_load & head_valid;
   assign is_last  = (pos_ff == (head_desc.explicit_rate ? HDR_LAST_EXPLICIT : HDR_LAST_BASE));
   assign pop      = emit & is_last;

   always_comb begin
      rsp_valid_in = out_load ? head_valid : 1'b1;
      pos_in       = pos_ff;
      if (emit) begin
         pos_in = is_last ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff     <= header_byte(head_desc, pos_ff);
         byte_pos_ff <= pos_ff;
         last_ff     <= is_last;
         ovf_ff      <= head_desc.overflow;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_header_byte     = byte_ff;
   assign rsp_byte_position   = byte_pos_ff;
   assign rsp_last_byte       = last_ff;
   assign rsp_length_overflow = ovf_ff;

endmodule

`default_nettype wire

// ===== src/adts_header_generator.sv =====
// a size word passes the front register, a queue entry and the byte register in turn
// throughput: one header byte per cycle while rsp_stall is low, 7 bytes per frame, 10
// when the rate is sent explicitly; the single output byte register sets that pace
// a frame queue between classifier and serializer lets a new word in while bytes drain
// reset (synchronous, active high) empties the queue, clears the byte counter and
// restores 48000 hz, one channel and profile code 1
`default_nettype none

module adts_header_generator #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire         clock,
   input  wire         reset,
   // configuration writes
   input  wire         csr_write_enable,
   input  wire  [1:0]  csr_index,
   input  wire  [23:0] csr_write_data,
   // payload size words
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [12:0] req_payload_size,
   // header byte words
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_header_byte,
   output logic [3:0]  rsp_byte_position,
   output logic        rsp_last_byte,
   output logic        rsp_length_overflow
);
   import adts_pkg::*;

   cfg_type        cfg_ff;
   frame_desc_type push_desc, head_desc;
   logic           push, pop, queue_full, head_valid;

   // configuration registers; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_hz  <= 24'd48000;
         cfg_ff.chan_num <= 4'd1;
         cfg_ff.profile  <= 2'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RATE_HZ:  cfg_ff.rate_hz  <= csr_write_data;
            CSR_CHAN_NUM: cfg_ff.chan_num <= csr_write_data[3:0];
            CSR_PROFILE:  cfg_ff.profile  <= csr_write_data[1:0];
            default:      cfg_ff <= cfg_ff;
         endcase
      end
   end

   // front: takes a word, looks up the rate index, forms frame length and overflow
   adts_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_size (req_payload_size),
      .push             (push),
      .push_desc        (push_desc),
      .queue_full       (queue_full)
   );

   // short queue of classified frames
   adts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   // back: walks the head frame one byte at a time, pops it on the last byte
   adts_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_desc           (head_desc),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_header_byte     (rsp_header_byte),
      .rsp_byte_position   (rsp_byte_position),
      .rsp_last_byte       (rsp_last_byte),
      .rsp_length_overflow (rsp_length_overflow)
   );

   // every header opens with the sync byte
   a_sync_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_position == POS_SYNC |-> rsp_header_byte == HDR_SYNC)
      else $error("header does not open with sync byte");

   // the last mark only sits on the final byte of a short or long header
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_byte |->
         rsp_byte_position == HDR_LAST_BASE || rsp_byte_position == HDR_LAST_EXPLICIT)
      else $error("last mark on a wrong byte position");

   // inside a header the bytes follow each other without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_byte |=>
         rsp_valid && rsp_byte_position == $past(rsp_byte_position) + 4'd1)
      else $error("gap or skip inside a header");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

`default_nettype wire
